FILE: rtl/socd_last_input_priority_assert.svh
// assertion macros shared by the socd rtl
`ifndef SOCD_LAST_INPUT_PRIORITY_ASSERT_SVH
`define SOCD_LAST_INPUT_PRIORITY_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define SOCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define SOCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/socd_pkg.sv
// shared types and constants of the socd last input priority block
`timescale 1ns / 1ps
`default_nettype none

package socd_pkg;

  localparam int unsigned NumSlots   = 4;
  localparam int unsigned NumGroups  = 4;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned PlanDepth  = 2;

  // slot words after reset: slots 0 and 1 hold key 0x41 and key 0x44, enabled, flash tap, group 1
  localparam logic [11:0] SlotResetWords [NumSlots] = '{12'h741, 12'h744, 12'h000, 12'h000};

  // configuration register indexes
  typedef enum logic [2:0] {
    CfgSlot0 = 3'd0,
    CfgSlot1 = 3'd1,
    CfgSlot2 = 3'd2,
    CfgSlot3 = 3'd3,
    CfgFlash = 3'd4
  } cfg_idx_e;

  // input transaction
  typedef struct packed {
    logic        cmd;
    logic [7:0]  key_code;
    logic        injected;
    logic [31:0] time_ms;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [7:0] out_key;
    logic       out_down;
    logic       out_passed;
    logic       out_last;
  } out_item_t;

  // one planned event
  typedef struct packed {
    logic [7:0] key;
    logic       down;
    logic       passed;
  } ev_t;

  // all events caused by one input, oldest in entry 0
  typedef struct packed {
    logic [2:0]                cnt;
    ev_t [MaxResults-1:0]      ev;
  } plan_t;

endpackage

`default_nettype wire

FILE: rtl/socd_front.sv
// front end: configuration, slot lookup, group state and event planning
`timescale 1ns / 1ps
`default_nettype none

module socd_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_wdata_i,
  input  wire logic              fire_i,
  input  wire socd_pkg::in_item_t item_i,
  output socd_pkg::plan_t        plan_o
);

  localparam int unsigned NS = socd_pkg::NumSlots;
  localparam int unsigned NG = socd_pkg::NumGroups;

  logic [11:0]   slot_word_q [NS];
  logic [15:0]   flash_window_q;
  logic [NS-1:0] held_q, held_d;
  logic [31:0]   press_time_q [NS];
  logic [31:0]   press_time_d [NS];
  logic [7:0]    active_q [NG];
  logic [7:0]    active_d [NG];
  logic [7:0]    prev_q [NG];
  logic [7:0]    prev_d [NG];

  logic          hit;
  logic [1:0]    s;
  logic [11:0]   w;
  logic          flash;
  logic [1:0]    g;
  logic [7:0]    act;
  logic [7:0]    prv;
  logic          held;
  logic [31:0]   dur;
  logic          in_window;
  logic [7:0]    key;
  socd_pkg::plan_t plan;

  function automatic socd_pkg::plan_t add_ev(socd_pkg::plan_t p, logic [7:0] k,
                                            logic dn, logic ps);
    socd_pkg::plan_t r;
    r = p;
    r.ev[p.cnt[1:0]] = '{key: k, down: dn, passed: ps};
    r.cnt = p.cnt + 3'd1;
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) slot_word_q[i] <= socd_pkg::SlotResetWords[i];
      flash_window_q <= '0;
    end else if (cfg_we_i) begin
      case (socd_pkg::cfg_idx_e'(cfg_idx_i))
        socd_pkg::CfgSlot0, socd_pkg::CfgSlot1,
        socd_pkg::CfgSlot2, socd_pkg::CfgSlot3: begin
          slot_word_q[cfg_idx_i[1:0]] <= cfg_wdata_i[11:0];
        end
        socd_pkg::CfgFlash: flash_window_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // lowest enabled slot with a matching non-zero key
  always_comb begin
    hit = 1'b0;
    s   = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (slot_word_q[i][8] && slot_word_q[i][7:0] == item_i.key_code &&
          item_i.key_code != 8'h00 && !item_i.injected) begin
        hit = 1'b1;
        s   = 2'(i);
      end
    end
  end

  assign key       = item_i.key_code;
  assign w         = slot_word_q[s];
  assign flash     = w[9];
  assign g         = w[11:10];
  assign act       = active_q[g];
  assign prv       = prev_q[g];
  assign held      = held_q[s];
  assign dur       = item_i.time_ms - press_time_q[s];
  assign in_window = dur <= {16'h0000, flash_window_q};

  // plan the events and the state update of this transaction
  always_comb begin
    plan         = '0;
    held_d       = held_q;
    press_time_d = press_time_q;
    active_d     = active_q;
    prev_d       = prev_q;
    if (!hit) begin
      plan = add_ev(plan, key, ~item_i.cmd, 1'b1);
    end else if (!item_i.cmd) begin
      if (!held) begin
        held_d[s] = 1'b1;
        if (flash) press_time_d[s] = item_i.time_ms;
        plan = add_ev(plan, key, 1'b1, 1'b0);
        active_d[g] = key;
        if (act != 8'h00 && act != key) begin
          prev_d[g] = act;
          plan = add_ev(plan, act, 1'b0, 1'b0);
        end
      end
    end else begin
      if (prv == key && !held) prev_d[g] = 8'h00;
      if (held) begin
        held_d[s] = 1'b0;
        if (flash && in_window) begin
          plan = add_ev(plan, key, 1'b1, 1'b0);
          plan = add_ev(plan, key, 1'b0, 1'b0);
        end
        if (act == key && prv != 8'h00) begin
          plan = add_ev(plan, key, 1'b0, 1'b0);
          active_d[g] = prv;
          prev_d[g]   = 8'h00;
          plan = add_ev(plan, prv, 1'b1, 1'b0);
        end else begin
          prev_d[g] = 8'h00;
          if (act == key) active_d[g] = 8'h00;
          plan = add_ev(plan, key, 1'b0, 1'b0);
        end
      end
    end
  end

  assign plan_o = plan;

  // key and group state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      for (int i = 0; i < NS; i++) press_time_q[i] <= '0;
      for (int i = 0; i < NG; i++) begin
        active_q[i] <= '0;
        prev_q[i]   <= '0;
      end
    end else if (fire_i) begin
      held_q       <= held_d;
      press_time_q <= press_time_d;
      active_q     <= active_d;
      prev_q       <= prev_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/socd_plan_fifo.sv
// short queue of event plans between front and back end
`timescale 1ns / 1ps
`default_nettype none

module socd_plan_fifo #(
  parameter int unsigned Depth = socd_pkg::PlanDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire socd_pkg::plan_t wr_plan_i,
  output logic                 full_o,
  output logic                 rd_valid_o,
  output socd_pkg::plan_t      rd_plan_o,
  input  wire logic            rd_en_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  socd_pkg::plan_t mem_q [Depth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_wr, do_rd;

  assign full_o     = cnt_q == CW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_plan_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  // plan storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_plan_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
      if (do_rd) rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/socd_back.sv
// back end: walks each plan and presents one result per cycle while results are popped
`timescale 1ns / 1ps
`default_nettype none

module socd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            plan_valid_i,
  input  wire socd_pkg::plan_t plan_i,
  output logic                 plan_done_o,
  output logic [1:0]           idx_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output socd_pkg::out_item_t  out_item_o
);

  logic [1:0]          idx_q;
  logic                out_valid_q;
  socd_pkg::out_item_t out_q;
  logic                ld;
  logic                last;
  socd_pkg::ev_t       ev;

  assign ld          = !out_valid_q || pop_i;
  assign ev          = plan_i.ev[idx_q];
  assign last        = {1'b0, idx_q} == plan_i.cnt - 3'd1;
  assign plan_done_o = ld && plan_valid_i && last;
  assign empty_o     = !out_valid_q;
  assign out_item_o  = out_q;
  assign idx_o       = idx_q;

  // output register
  always_ff @(posedge clk_i) begin
    if (ld && plan_valid_i) begin
      out_q <= '{out_key: ev.key, out_down: ev.down, out_passed: ev.passed, out_last: last};
    end
  end

  // event index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (ld) begin
      out_valid_q <= plan_valid_i;
      if (plan_valid_i) idx_q <= last ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/socd_last_input_priority.sv
// top level of the socd last input priority key cleaner
`timescale 1ns / 1ps
`default_nettype none
`include "socd_last_input_priority_assert.svh"

// Key event cleaner for opposing keys: the last pressed key of a group wins.
// Events are pushed as transactions on the input queue side (push / full) and
// results are taken from the output queue side (empty / pop). The front end
// takes one event per clock while the plan queue has room, updates the slot
// and group state at once and writes all results of that event (one to four)
// as one plan. The back end sends one result per clock while results are
// popped and takes the next plan only after the last result of a plan; the
// first result passes the plan queue and the output register on its way out.
// Events that cause no result leave nothing in the queue. Configuration
// writes take effect at once and are meant for times when the block is idle.

module socd_last_input_priority #(
  parameter int unsigned PlanDepth = socd_pkg::PlanDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [2:0]          cfg_idx_i,
  input  wire logic [15:0]         cfg_wdata_i,
  input  wire logic                push,
  output logic                     full,
  input  wire socd_pkg::in_item_t  in_item_i,
  output logic                     empty,
  input  wire logic                pop,
  output socd_pkg::out_item_t      out_item_o
);

  logic            fire;
  logic            plan_push;
  logic            plan_valid;
  logic            plan_done;
  logic [1:0]      back_idx;
  socd_pkg::plan_t plan_in;
  socd_pkg::plan_t plan_out;

  assign fire      = push && !full;
  assign plan_push = fire && plan_in.cnt != 3'd0;

  // classify and plan
  socd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (in_item_i),
    .plan_o      (plan_in)
  );

  // plan queue
  socd_plan_fifo #(
    .Depth (PlanDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (plan_push),
    .wr_plan_i  (plan_in),
    .full_o     (full),
    .rd_valid_o (plan_valid),
    .rd_plan_o  (plan_out),
    .rd_en_i    (plan_done)
  );

  // result sequencing
  socd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (plan_valid),
    .plan_i       (plan_out),
    .plan_done_o  (plan_done),
    .idx_o        (back_idx),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_item_o   (out_item_o)
  );

  // checks
  `SOCD_ASSERT_IMP(plan_cnt_range_a, plan_push, plan_in.cnt <= 3'd4, "plan count out of range")
  `SOCD_ASSERT_IMP(back_idx_range_a, plan_valid, {1'b0, back_idx} < plan_out.cnt, "index beyond plan")
  `SOCD_ASSERT_NXT(result_source_a, empty && !plan_valid, empty, "result without a plan")

endmodule

`default_nettype wire
